>>> hdl/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// Shared widths, register map and coefficient bundle of the Q15 biquad.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = SAMPLE_W - 1;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = 40;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [REG_IDX_W-1:0]       reg_idx_t;

    localparam reg_idx_t REG_B0      = 3'd0;
    localparam reg_idx_t REG_B1_HALF = 3'd1;
    localparam reg_idx_t REG_B2      = 3'd2;
    localparam reg_idx_t REG_A1_HALF = 3'd3;
    localparam reg_idx_t REG_A2      = 3'd4;

    typedef struct packed {
        sample_t b0;
        sample_t b1_half;
        sample_t b2;
        sample_t a1_half;
        sample_t a2;
    } coefs_t;

endpackage

`default_nettype wire

>>> hdl/biq_if.sv
// ----------------------------------------------------------------------------
// biq_if
// Valid/ready item channels for input and output samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface biq_in_if
    import biq_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if
    import biq_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> hdl/biq_apb_regs.sv
// ----------------------------------------------------------------------------
// biq_apb_regs
// APB coefficient register file, five signed Q15 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_apb_regs
    import biq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output coefs_t                     coefs
);

    coefs_t   coefs_reg;
    reg_idx_t idx;
    sample_t  wr_val;
    sample_t  rd_val;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_val = sample_t'(pwdata[SAMPLE_W-1:0]);
    assign pready = 1'b1;
    assign coefs  = coefs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_B0:      coefs_reg.b0      <= wr_val;
                REG_B1_HALF: coefs_reg.b1_half <= wr_val;
                REG_B2:      coefs_reg.b2      <= wr_val;
                REG_A1_HALF: coefs_reg.a1_half <= wr_val;
                REG_A2:      coefs_reg.a2      <= wr_val;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_B0:      rd_val = coefs_reg.b0;
            REG_B1_HALF: rd_val = coefs_reg.b1_half;
            REG_B2:      rd_val = coefs_reg.b2;
            REG_A1_HALF: rd_val = coefs_reg.a1_half;
            REG_A2:      rd_val = coefs_reg.a2;
            default:     rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_val);

endmodule

`default_nettype wire

>>> hdl/biq_core.sv
// ----------------------------------------------------------------------------
// biq_core
// Direct form I multiply-accumulate, floor shift, saturation and history.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_core
    import biq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire sample_t x,
    input  wire coefs_t  coefs,
    output sample_t      y
);

    localparam acc_t ACC_SAT_MAX = acc_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
    localparam acc_t ACC_SAT_MIN = -ACC_SAT_MAX - acc_t'(1);

    sample_t x1_reg;
    sample_t x2_reg;
    sample_t y1_reg;
    sample_t y2_reg;

    prod_t p_b0;
    prod_t p_b1;
    prod_t p_b2;
    prod_t p_a1;
    prod_t p_a2;
    acc_t  acc;
    acc_t  shifted;

    assign p_b0 = coefs.b0      * x;
    assign p_b1 = coefs.b1_half * x1_reg;
    assign p_b2 = coefs.b2      * x2_reg;
    assign p_a1 = coefs.a1_half * y1_reg;
    assign p_a2 = coefs.a2      * y2_reg;

    // half-scale taps count twice
    assign acc = acc_t'(p_b0) + (acc_t'(p_b1) <<< 1) + acc_t'(p_b2)
               + (acc_t'(p_a1) <<< 1) + acc_t'(p_a2);

    assign shifted = acc >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > ACC_SAT_MAX)
            y = ACC_SAT_MAX[SAMPLE_W-1:0];
        else if (shifted < ACC_SAT_MIN)
            y = ACC_SAT_MIN[SAMPLE_W-1:0];
        else
            y = shifted[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (advance)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x;
            y2_reg <= y1_reg;
            y1_reg <= y;
        end
    end

endmodule

`default_nettype wire

>>> hdl/q15_biquad_iir_df1.sv
// ----------------------------------------------------------------------------
// q15_biquad_iir_df1 - Q15 biquad IIR filter, direct form I
// Input register, then one MAC pass into the output register.
// Throughput 1 item per cycle while the output is not stalled; y1 feedback closes within that single pass.
// rst_n (async, active low) clears coefficients, history and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module q15_biquad_iir_df1
    import biq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    biq_in_if.sink                     in_stream,
    biq_out_if.source                  out_stream,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    coefs_t  coefs;
    logic    in_valid_reg;
    sample_t in_sample_reg;
    logic    out_valid_reg;
    sample_t out_sample_reg;
    logic    advance;
    logic    in_take;
    sample_t y;

    biq_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    biq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .x       (in_sample_reg),
        .coefs   (coefs),
        .y       (y)
    );

    assign advance         = in_valid_reg && (!out_valid_reg || out_stream.ready);
    assign in_stream.ready = !in_valid_reg || advance;
    assign in_take         = in_stream.valid && in_stream.ready;

    assign out_stream.valid      = out_valid_reg;
    assign out_stream.sample_out = out_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_stream.ready)
                in_valid_reg <= in_stream.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_sample_reg <= in_stream.sample_in;
        if (advance)
            out_sample_reg <= y;
    end

    // held output item blocks the MAC pass
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stream.ready |-> !advance)
        else $error("MAC pass while output item stalled");

    a_pass_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("output register empty after MAC pass");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_sample_reg))
        else $error("pending input item lost");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_stream.ready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> dv/tb_q15_biquad_iir_df1.sv
// ----------------------------------------------------------------------------
// tb_q15_biquad_iir_df1
// Self-checking bench for the Q15 direct form I biquad. Coefficients are
// loaded over APB while the filter is drained. Samples stream in with random
// source gaps and sink stalls. An in-bench filter model predicts each output,
// including the floor shift and saturation, and a checker compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_q15_biquad_iir_df1;
    import biq_pkg::*;

    typedef enum int {MIX_FULL, MIX_SMALL, MIX_EDGE} mix_t;

    localparam int       PHASES       = 8;
    localparam int       PHASE_ITEMS  = 240;
    localparam int       IDLE_PCT     = 6;
    localparam sample_t  EDGE_VALS[7] = '{16'sh8000, 16'sh8001, 16'shffff, 16'sh0000,
                                          16'sh0001, 16'sh7ffe, 16'sh7fff};

    logic clk = 1'b0;
    logic rst_n;
    always #5 clk = ~clk;

    biq_in_if  in_stream ();
    biq_out_if out_stream ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    q15_biquad_iir_df1 u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream.sink),
        .out_stream (out_stream.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    coefs_t  coef_shadow;
    sample_t hist_x1, hist_x2, hist_y1, hist_y2;
    sample_t filtered_q[$];
    int      fail_count;
    bit      steady_flow;

    function automatic sample_t filter_step(input sample_t x);
        longint acc;
        longint y;
        acc = longint'(coef_shadow.b0) * x
            + 2 * longint'(coef_shadow.b1_half) * hist_x1
            + longint'(coef_shadow.b2) * hist_x2
            + 2 * longint'(coef_shadow.a1_half) * hist_y1
            + longint'(coef_shadow.a2) * hist_y2;
        y = acc >>> FRAC_BITS;
        if (y > 32767)
            y = 32767;
        else if (y < -32768)
            y = -32768;
        hist_x2 = hist_x1;
        hist_x1 = x;
        hist_y2 = hist_y1;
        hist_y1 = sample_t'(y);
        return sample_t'(y);
    endfunction

    function automatic sample_t pick_value(input mix_t mix);
        case (mix)
            MIX_SMALL: return sample_t'(int'($urandom_range(8191)) - 4096);
            MIX_EDGE:  return EDGE_VALS[$urandom_range(6)];
            default:   return sample_t'($urandom());
        endcase
    endfunction

    function automatic mix_t pick_sample_mix();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return MIX_FULL;
        if (r < 85)
            return MIX_SMALL;
        return MIX_EDGE;
    endfunction

    // receiver side
    initial out_stream.ready = 1'b0;
    always @(posedge clk)
        out_stream.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk) begin
        sample_t want;
        if (rst_n && out_stream.valid && out_stream.ready) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected sample_out %0d, expected none", $time,
                         out_stream.sample_out);
                fail_count++;
            end else begin
                want = filtered_q.pop_front();
                if (out_stream.sample_out !== want) begin
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d", $time,
                             want, out_stream.sample_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(input sample_t x);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            in_stream.valid <= 1'b0;
            @(posedge clk);
        end
        in_stream.valid     <= 1'b1;
        in_stream.sample_in <= x;
        do @(posedge clk); while (!in_stream.ready);
        filtered_q.push_back(filter_step(x));
    endtask

    task automatic drain_filter();
        in_stream.valid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input sample_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_B0:      coef_shadow.b0      = value;
            REG_B1_HALF: coef_shadow.b1_half = value;
            REG_B2:      coef_shadow.b2      = value;
            REG_A1_HALF: coef_shadow.a1_half = value;
            REG_A2:      coef_shadow.a2      = value;
            default:     ;
        endcase
    endtask

    task automatic load_coefs(input coefs_t c);
        drain_filter();
        apb_write(REG_B0, c.b0);
        apb_write(REG_B1_HALF, c.b1_half);
        apb_write(REG_B2, c.b2);
        apb_write(REG_A1_HALF, c.a1_half);
        apb_write(REG_A2, c.a2);
    endtask

    task automatic test_zero_coefs_after_reset();
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
    endtask

    task automatic test_unmapped_writes();
        load_coefs('{b0: 16'sh8000, default: 16'sh0000});
        for (int i = REG_A2 + 1; i < (1 << REG_IDX_W); i++)
            apb_write(reg_idx_t'(i), sample_t'($urandom()));
        send_sample(16'sh8000);
        send_sample(16'sd12345);
        send_sample(16'shffff);
    endtask

    task automatic test_positive_saturation();
        load_coefs('{default: 16'sh7fff});
        repeat (3) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);
    endtask

    task automatic test_negative_extremes();
        load_coefs('{default: 16'sh8000});
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        send_sample(16'sh0000);
    endtask

    task automatic test_floor_rounding();
        load_coefs('{b0: 16'sh0001, default: 16'sh0000});
        send_sample(16'shffff);
        send_sample(16'sh0001);
        load_coefs('{b0: 16'sh4000, b1_half: 16'shc000, default: 16'sh0000});
        send_sample(16'sh0003);
        send_sample(16'shfffd);
    endtask

    task automatic test_random_phases();
        coefs_t c;
        mix_t   cmix;
        for (int p = 0; p < PHASES; p++) begin
            cmix      = mix_t'(p % 3);
            c.b0      = pick_value(cmix);
            c.b1_half = pick_value(cmix);
            c.b2      = pick_value(cmix);
            c.a1_half = pick_value(cmix);
            c.a2      = pick_value(cmix);
            load_coefs(c);
            steady_flow = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2)
                    drain_filter();
                send_sample(pick_value(pick_sample_mix()));
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        #2_000_000;
        $display("** q15_biquad_iir_df1: FAILED **");
        $finish;
    end

    initial begin
        rst_n               = 1'b0;
        in_stream.valid     = 1'b0;
        in_stream.sample_in = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        coef_shadow         = '0;
        hist_x1             = '0;
        hist_x2             = '0;
        hist_y1             = '0;
        hist_y2             = '0;
        fail_count          = 0;
        steady_flow         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_coefs_after_reset();
        test_unmapped_writes();
        test_positive_saturation();
        test_negative_extremes();
        test_floor_rounding();
        test_random_phases();

        drain_filter();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** q15_biquad_iir_df1: PASSED **");
        else
            $display("** q15_biquad_iir_df1: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/biq_pkg.sv
hdl/biq_if.sv
hdl/biq_apb_regs.sv
hdl/biq_core.sv
hdl/q15_biquad_iir_df1.sv
dv/tb_q15_biquad_iir_df1.sv
